### sv/bitmap_frame_allocator_macros.svh
// assertion macros for the bitmap frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BFA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BFA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### sv/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
package bfa_pkg;

    localparam int FRAME_W = 12;
    localparam int LIMIT_W = 13;
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;
    localparam int PAGE_LIMIT_RESET = 4096;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic {
        REG_PAGE_LIMIT = 1'b0,
        REG_NONE       = 1'b1
    } reg_idx_t;

    typedef struct packed {
        func_t              func;
        logic [FRAME_W-1:0] frame;
        logic               in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_MOD,
        ST_FILL_RD,
        ST_FILL_LD,
        ST_FILL_SCAN,
        ST_OUT
    } back_state_t;

endpackage

### sv/bitmap_frame_allocator.sv
// top level of the bitmap page frame allocator
// one used bit per frame, kept in a map memory of 32-bit words that is set to all
// used by a clearing pass over its ceil(NUM_FRAMES/32) words after reset (128 at the
// default size); up to two request transactions may queue meanwhile but none is served. a
// request (tuser[0]=0 allocate, 1 free) is classified by the front end and queued; the
// back end then works on one request at a time. a free dequeues the request with a map
// read, then does the modify-write, then loads the result (a free past the map skips
// the modify-write). an allocate served from the prefetch buffer dequeues and then
// loads the result. an allocate at buffer position zero first refills the whole buffer:
// the map is walked word by word from frame 0, each word visited being read, loaded and
// scanned, with one frame taken per scan step, stopping after PREFETCH_DEPTH frames or
// at page_limit. buffer entries that the refill could not fill come out with found
// clear and frame zero. the result register lets the next request start while a result
// transaction waits.
module bitmap_frame_allocator #(
    parameter int NUM_FRAMES     = 4096,
    parameter int PREFETCH_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] frame_number
    input  logic [0:0]  s_tuser,   // [0] func
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] frame_number_res
    output logic [0:0]  m_tuser,   // [0] found
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfa_pkg::*;

    logic [LIMIT_W-1:0] page_limit_reg, page_limit_next;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    logic               q_push, q_full, q_pop, q_valid;
    cmd_t               push_cmd, pop_cmd;
    logic [FRAME_W-1:0] m_frame;
    logic               m_found;

    // register index from the word address
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        page_limit_next = page_limit_reg;
        if (cfg_wr && reg_idx == REG_PAGE_LIMIT) begin
            page_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= LIMIT_W'(PAGE_LIMIT_RESET);
        end else begin
            page_limit_reg <= page_limit_next;
        end
    end

    // reads of unused addresses return zero
    assign prdata = (reg_idx == REG_PAGE_LIMIT) ? 32'(page_limit_reg) : 32'd0;

    // front end classifies the request transaction
    bfa_front #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // decouples the front end from the back end
    bfa_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_cmd (pop_cmd)
    );

    // map memory, prefetch buffer and result register
    bfa_back #(
        .NUM_FRAMES    (NUM_FRAMES),
        .PREFETCH_DEPTH(PREFETCH_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .page_limit(page_limit_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_frame   (m_frame),
        .m_found   (m_found)
    );

    assign m_tdata = 16'(m_frame);
    assign m_tuser = m_found;
endmodule

### sv/bfa_front.sv
// front end: accepts requests and classifies them into commands
module bfa_front #(
    parameter int NUM_FRAMES = 4096
) (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic [0:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output bfa_pkg::cmd_t q_cmd
);
    import bfa_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.func     = func_t'(s_tuser[0]);
        q_cmd.frame    = s_tdata[FRAME_W-1:0];
        // frames past the map are echoed back with found clear
        q_cmd.in_range = (32'(s_tdata[FRAME_W-1:0]) < 32'(NUM_FRAMES));
    end
endmodule

### sv/bfa_cmd_fifo.sv
// two-entry command queue between front and back end
module bfa_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bfa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output bfa_pkg::cmd_t pop_cmd
);
    import bfa_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // no request transaction is taken while reset is held
    assign full    = (cnt_reg == 2'd2) || !aresetn;
    assign valid   = (cnt_reg != 2'd0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

### sv/bfa_back.sv
// back end: used map memory, prefetch buffer refill and result register
`include "bitmap_frame_allocator_macros.svh"
module bfa_back #(
    parameter int NUM_FRAMES     = 4096,
    parameter int PREFETCH_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  bfa_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    input  logic [bfa_pkg::LIMIT_W-1:0] page_limit,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bfa_pkg::FRAME_W-1:0] m_frame,
    output logic                        m_found
);
    import bfa_pkg::*;

    localparam int ROWS  = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIMW  = ($clog2(NUM_FRAMES + 1) > LIMIT_W) ? $clog2(NUM_FRAMES + 1)
                                                               : LIMIT_W;
    localparam int PW    = (PREFETCH_DEPTH > 1) ? $clog2(PREFETCH_DEPTH) : 1;
    localparam int CW    = $clog2(PREFETCH_DEPTH + 1);
    localparam int XW    = (RW + WORD_SH > FRAME_W) ? RW + WORD_SH : FRAME_W;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [CW-1:0]      fill_cnt_reg, fill_cnt_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic               res_found_reg, res_found_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic               m_found_reg, m_found_next;

    logic [FRAME_W-1:0] entry_mem [PREFETCH_DEPTH];
    logic               entry_we;
    logic [FRAME_W-1:0] entry_wd;

    logic [WORD_W-1:0]  map_mem [ROWS];
    logic               mem_we;
    logic [RW-1:0]      mem_wa, mem_ra;
    logic [WORD_W-1:0]  mem_wd, mem_q;

    logic [XW-1:0]      q_fx, c_fx;
    logic [LIMW-1:0]    lim_raw, lim, base, rem;
    logic [WORD_W-1:0]  mask, free_bits, hit_bit;
    logic [WORD_SH-1:0] hit_idx;
    logic               hit, in_lim, out_free, pos_hit;

    assign q_fx    = XW'(q_cmd.frame);
    assign c_fx    = XW'(cmd_reg.frame);
    assign lim_raw = LIMW'(page_limit);
    assign lim     = (lim_raw > LIMW'(NUM_FRAMES)) ? LIMW'(NUM_FRAMES) : lim_raw;
    assign base    = LIMW'({row_reg, {WORD_SH{1'b0}}});
    assign in_lim  = (base < lim);
    assign rem     = lim - base;
    assign mask    = (rem >= LIMW'(WORD_W)) ? '1
                   : ((WORD_W'(1) << rem[WORD_SH-1:0]) - WORD_W'(1));
    assign free_bits = ~word_reg & mask;
    assign hit       = (free_bits != '0);
    assign hit_bit   = WORD_W'(1) << hit_idx;
    assign out_free  = !m_tvalid_reg || m_tready;
    // entries past the fill count were empty scans
    assign pos_hit   = (CW'(pos_reg) < fill_cnt_reg);

    // lowest free bit of the current map word
    always_comb begin
        hit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_idx = WORD_SH'(b);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        word_next      = word_reg;
        fill_cnt_next  = fill_cnt_reg;
        pos_next       = pos_reg;
        res_frame_next = res_frame_reg;
        res_found_next = res_found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_frame_next   = m_frame_reg;
        m_found_next   = m_found_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = row_reg;
        mem_wd         = word_reg;
        mem_ra         = row_reg;
        entry_we       = 1'b0;
        entry_wd       = FRAME_W'({row_reg, hit_idx});
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = '1;
                if (row_reg == RW'(ROWS - 1)) begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end
            ST_IDLE: begin
                mem_ra = q_fx[RW+WORD_SH-1:WORD_SH];
                if (q_valid) begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    res_frame_next = q_cmd.frame;
                    res_found_next = 1'b0;
                    if (q_cmd.func == FUNC_FREE) begin
                        state_next = q_cmd.in_range ? ST_FREE_MOD : ST_OUT;
                    end else if (pos_reg == '0) begin
                        row_next      = '0;
                        fill_cnt_next = '0;
                        state_next    = ST_FILL_RD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FREE_MOD: begin
                mem_we         = 1'b1;
                mem_wa         = c_fx[RW+WORD_SH-1:WORD_SH];
                mem_wd         = mem_q & ~(WORD_W'(1) << cmd_reg.frame[WORD_SH-1:0]);
                res_found_next = 1'b1;
                state_next     = ST_OUT;
            end
            ST_FILL_RD: begin
                state_next = ST_FILL_LD;
            end
            ST_FILL_LD: begin
                word_next  = mem_q;
                state_next = ST_FILL_SCAN;
            end
            ST_FILL_SCAN: begin
                if (!in_lim) begin
                    state_next = ST_OUT;
                end else if (hit) begin
                    entry_we      = 1'b1;
                    word_next     = word_reg | hit_bit;
                    fill_cnt_next = fill_cnt_reg + CW'(1);
                    if (fill_cnt_reg == CW'(PREFETCH_DEPTH - 1)) begin
                        mem_we     = 1'b1;
                        mem_wd     = word_reg | hit_bit;
                        state_next = ST_OUT;
                    end
                end else begin
                    mem_we = 1'b1;
                    if (row_reg == RW'(ROWS - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        row_next   = row_reg + RW'(1);
                        state_next = ST_FILL_RD;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (cmd_reg.func == FUNC_ALLOC) begin
                        m_frame_next = pos_hit ? entry_mem[pos_reg] : '0;
                        m_found_next = pos_hit;
                        pos_next     = (pos_reg == PW'(PREFETCH_DEPTH - 1)) ? '0
                                                                         : pos_reg + PW'(1);
                    end else begin
                        m_frame_next = res_frame_reg;
                        m_found_next = res_found_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            row_reg      <= '0;
            fill_cnt_reg <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            fill_cnt_reg <= fill_cnt_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        word_reg      <= word_next;
        res_frame_reg <= res_frame_next;
        res_found_reg <= res_found_next;
        m_frame_reg   <= m_frame_next;
        m_found_reg   <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[fill_cnt_reg[PW-1:0]] <= entry_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_wa] <= mem_wd;
        end
        mem_q <= map_mem[mem_ra];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_frame  = m_frame_reg;
    assign m_found  = m_found_reg;

    `BFA_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_cnt_reg <= CW'(PREFETCH_DEPTH))
    `BFA_ASSERT_IMPL(a_pop_idle, aclk, aresetn, q_pop, state_reg == ST_IDLE)
    `BFA_ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == ST_OUT && out_free, m_tvalid_reg && state_reg == ST_IDLE)
endmodule
